/* hdl/wed_pkg.sv */
// shared types, constants and saturating helpers of the alignment cost engine
// no dependencies; used by wed_cell, weighted_edit_distance_engine and the testbench
package wed_pkg;

  localparam int MAX_LEN     = 256;
  localparam int SYMBOL_BITS = 16;

  // symbol field is 16 bits wide, compared on its low SYMBOL_BITS
  localparam int SYM_FIELD_W = 16;
  localparam int SYM_W       = (SYMBOL_BITS < SYM_FIELD_W) ? SYMBOL_BITS : SYM_FIELD_W;

  localparam int PEN_W   = 8;
  localparam int CELL_W  = 18;
  localparam int COST_W  = 17;
  localparam int ACNT_W  = $clog2(MAX_LEN + 1);
  localparam int TCNT_W  = $clog2(MAX_LEN + 2);
  localparam int PROD_W  = (ACNT_W + PEN_W > CELL_W) ? ACNT_W + PEN_W : CELL_W;
  localparam int CFG_IDX_W = 2;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 24;

  localparam logic [CELL_W-1:0] CELL_MAX = {CELL_W{1'b1}};
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // input item kinds
  localparam logic [1:0] MODE_LOAD_A  = 2'd0;
  localparam logic [1:0] MODE_B_SYM   = 2'd1;
  localparam logic [1:0] MODE_FINISH  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MISMATCH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_A   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_B   = 2'd2;

  typedef logic [CELL_W-1:0] cell_t;

  typedef struct packed {
    logic [PEN_W-1:0] mismatch;
    logic [PEN_W-1:0] skip_a;
    logic [PEN_W-1:0] skip_b;
  } pen_t;

  // one wavefront token moving along the chain
  typedef struct packed {
    logic             valid;
    logic             init;   // first column: old cells read as gap ramp
    logic             last;
    logic [SYM_W-1:0] sym;
    cell_t            up;     // new value of the cell before
    cell_t            diag;   // old value of the cell before
  } tok_t;

  function automatic cell_t sat_add(input cell_t c, input logic [PEN_W-1:0] p);
    logic [CELL_W:0] s;
    s = {1'b0, c} + {{(CELL_W + 1 - PEN_W){1'b0}}, p};
    return s[CELL_W] ? CELL_MAX : s[CELL_W-1:0];
  endfunction

  function automatic cell_t min_cell(input cell_t a, input cell_t b);
    return (b < a) ? b : a;
  endfunction

  function automatic logic [COST_W-1:0] to_cost(input cell_t c);
    return (c > {1'b0, COST_MAX}) ? COST_MAX : c[COST_W-1:0];
  endfunction

endpackage

/* hdl/wed_cell.sv */
// one cell of the systolic row: holds one A symbol and one cost-column entry
// depends on wed_pkg
module wed_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wed_pkg::pen_t                pen_i,
  input  logic                         load_en_i,
  input  logic                         clear_i,
  input  logic [wed_pkg::SYM_W-1:0]    load_sym_i,
  input  wed_pkg::tok_t                tok_i,
  output wed_pkg::tok_t                tok_o
);

  logic                      active_q;
  logic [wed_pkg::SYM_W-1:0] sym_q;
  wed_pkg::cell_t            cost_q;
  wed_pkg::tok_t             tok_q;

  wed_pkg::cell_t here_old;
  wed_pkg::cell_t diag_c;
  wed_pkg::cell_t up_c;
  wed_pkg::cell_t left_c;
  wed_pkg::cell_t best;
  wed_pkg::cell_t new_c;
  logic [wed_pkg::PEN_W-1:0] sub_pen;

  always_comb begin
    here_old = tok_i.init ? wed_pkg::sat_add(tok_i.diag, pen_i.skip_a) : cost_q;
    sub_pen  = (sym_q == tok_i.sym) ? '0 : pen_i.mismatch;
    diag_c   = wed_pkg::sat_add(tok_i.diag, sub_pen);
    up_c     = wed_pkg::sat_add(tok_i.up, pen_i.skip_a);
    left_c   = wed_pkg::sat_add(here_old, pen_i.skip_b);
    best     = wed_pkg::min_cell(wed_pkg::min_cell(diag_c, up_c), left_c);
    // cells past the end of A just hand the value on
    new_c    = active_q ? best : tok_i.up;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (load_en_i) begin
      active_q <= 1'b1;
    end else if (clear_i) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.valid <= tok_i.valid;
      tok_q.init  <= tok_i.init;
      tok_q.last  <= tok_i.last;
      tok_q.sym   <= tok_i.sym;
      tok_q.up    <= new_c;
      tok_q.diag  <= here_old;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      sym_q <= load_sym_i;
    end
    if (tok_i.valid && active_q) begin
      cost_q <= best;
    end
  end

  assign tok_o = tok_q;

endmodule

/* hdl/weighted_edit_distance_engine.sv */
// top level of the weighted global alignment cost engine
// depends on wed_pkg and wed_cell
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid_i/tready_o       tdata: symbol; tuser: mode, start_req; tlast: last
// m_axis    out  m_axis_tvalid_o/tready_i       tdata: cost; tuser: overflow
// cfg       in   cfg_we_i (no wait)             cfg_idx_i selects register, cfg_data_i value
//
// B symbols enter one per cycle while ready (a last one may wait) and ripple through the row of
// MAX_LEN cells, one cell per cycle; a result is registered as its last token leaves the row
// A loads wait until the row is empty, empty-B finishes also until the output is free
// a last B symbol waits until the previous result is taken and out of the row
// reset clears control state and sets all penalties to 1; cells need no clearing
// m_axis stalls only hold the output register, the row never stops
module weighted_edit_distance_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream in
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [wed_pkg::SYM_FIELD_W-1:0]   s_axis_tdata_i,   // [15:0] symbol
  input  logic [wed_pkg::IN_USER_W-1:0]     s_axis_tuser_i,   // [1:0] mode, [2] start_req
  input  logic                              s_axis_tlast_i,   // last
  // stream out
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [wed_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,   // [16:0] cost, rest zero
  output logic                              m_axis_tuser_o,   // [0] overflow
  // configuration writes
  input  logic                              cfg_we_i,
  input  logic [wed_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [wed_pkg::PEN_W-1:0]         cfg_data_i
);

  // input fields
  logic [1:0]                mode;
  logic                      start;
  logic [wed_pkg::SYM_W-1:0] sym;

  assign mode  = s_axis_tuser_i[1:0];
  assign start = s_axis_tuser_i[2];
  assign sym   = s_axis_tdata_i[wed_pkg::SYM_W-1:0];

  // penalties
  wed_pkg::pen_t pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q.mismatch <= wed_pkg::PEN_W'(1);
      pen_q.skip_a   <= wed_pkg::PEN_W'(1);
      pen_q.skip_b   <= wed_pkg::PEN_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        wed_pkg::REG_MISMATCH: pen_q.mismatch <= cfg_data_i;
        wed_pkg::REG_SKIP_A:   pen_q.skip_a   <= cfg_data_i;
        wed_pkg::REG_SKIP_B:   pen_q.skip_b   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // control state
  logic [wed_pkg::ACNT_W-1:0] a_count_q, a_count_d;
  logic                       a_dropped_q, a_dropped_d;
  logic                       col_live_q, col_live_d;   // b progress nonzero
  logic                       last_busy_q, last_busy_d; // a last token is in the row
  logic [wed_pkg::TCNT_W-1:0] inflight_q, inflight_d;
  logic                       out_valid_q, out_valid_d;
  logic [wed_pkg::COST_W-1:0] out_cost_q;
  logic                       out_ovf_q;

  wed_pkg::cell_t c0_q;
  wed_pkg::tok_t  tok0_q;
  wed_pkg::tok_t  tok [0:wed_pkg::MAX_LEN];
  wed_pkg::tok_t  chain_out;

  assign tok[0]    = tok0_q;
  assign chain_out = tok[wed_pkg::MAX_LEN];

  logic row_empty;
  logic ready;
  logic fire;
  logic load_fire, b_fire, fin_fire;
  logic result_fire;

  assign row_empty = (inflight_q == '0);

  always_comb begin
    case (mode)
      wed_pkg::MODE_LOAD_A: ready = row_empty;
      wed_pkg::MODE_B_SYM:  ready = !s_axis_tlast_i || (!last_busy_q && !out_valid_q);
      wed_pkg::MODE_FINISH: ready = row_empty && !out_valid_q;
      default:              ready = 1'b1;
    endcase
  end

  assign s_axis_tready_o = ready;
  assign fire      = s_axis_tvalid_i && ready;
  assign load_fire = fire && (mode == wed_pkg::MODE_LOAD_A);
  assign b_fire    = fire && (mode == wed_pkg::MODE_B_SYM);
  assign fin_fire  = fire && (mode == wed_pkg::MODE_FINISH);
  assign result_fire = chain_out.valid && chain_out.last;

  // a load goes to slot 0 on a fresh sequence, else to the next free slot
  logic [wed_pkg::ACNT_W-1:0] load_idx;
  logic                       load_fits;

  assign load_idx  = start ? '0 : a_count_q;
  assign load_fits = (load_idx < wed_pkg::ACNT_W'(wed_pkg::MAX_LEN));

  // entry stage: row 0 of the cost matrix
  logic           init;
  wed_pkg::cell_t old0;
  wed_pkg::cell_t new0;

  assign init = start || !col_live_q;
  assign old0 = init ? '0 : c0_q;
  assign new0 = wed_pkg::sat_add(old0, pen_q.skip_b);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok0_q <= '0;
    end else begin
      tok0_q.valid <= b_fire;
      tok0_q.init  <= init;
      tok0_q.last  <= s_axis_tlast_i;
      tok0_q.sym   <= sym;
      tok0_q.up    <= new0;
      tok0_q.diag  <= old0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      c0_q <= new0;
    end
  end

  // the row of cells, one per A position
  for (genvar g = 0; g < wed_pkg::MAX_LEN; g++) begin : g_cell
    wed_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .pen_i      (pen_q),
      .load_en_i  (load_fire && load_fits && (load_idx == wed_pkg::ACNT_W'(g))),
      .clear_i    (load_fire && start),
      .load_sym_i (sym),
      .tok_i      (tok[g]),
      .tok_o      (tok[g+1])
    );
  end

  // empty-B finish: a_count gap steps, which cannot wrap below the cell limit
  logic [wed_pkg::PROD_W-1:0] fin_prod;
  wed_pkg::cell_t             fin_cell;

  assign fin_prod = wed_pkg::PROD_W'(a_count_q) * wed_pkg::PROD_W'(pen_q.skip_a);
  assign fin_cell = (fin_prod > wed_pkg::PROD_W'(wed_pkg::CELL_MAX)) ?
                    wed_pkg::CELL_MAX : fin_prod[wed_pkg::CELL_W-1:0];

  always_comb begin
    a_count_d   = a_count_q;
    a_dropped_d = a_dropped_q;
    col_live_d  = col_live_q;
    last_busy_d = last_busy_q;
    inflight_d  = inflight_q + wed_pkg::TCNT_W'(b_fire) - wed_pkg::TCNT_W'(chain_out.valid);
    out_valid_d = out_valid_q && !m_axis_tready_i;

    if (load_fire) begin
      col_live_d = 1'b0;
      if (start) begin
        a_dropped_d = 1'b0;
      end
      if (load_fits) begin
        a_count_d = load_idx + wed_pkg::ACNT_W'(1);
      end else begin
        a_count_d   = load_idx;
        a_dropped_d = 1'b1;
      end
    end
    if (b_fire) begin
      col_live_d = !s_axis_tlast_i;
      if (s_axis_tlast_i) begin
        last_busy_d = 1'b1;
      end
    end
    if (fin_fire) begin
      col_live_d = 1'b0;
    end
    if (result_fire) begin
      last_busy_d = 1'b0;
    end
    if (result_fire || fin_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_count_q   <= '0;
      a_dropped_q <= 1'b0;
      col_live_q  <= 1'b0;
      last_busy_q <= 1'b0;
      inflight_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      a_count_q   <= a_count_d;
      a_dropped_q <= a_dropped_d;
      col_live_q  <= col_live_d;
      last_busy_q <= last_busy_d;
      inflight_q  <= inflight_d;
      out_valid_q <= out_valid_d;
    end
  end

  // output register; a_dropped cannot change while a result is on its way
  always_ff @(posedge clk_i) begin
    if (result_fire) begin
      out_cost_q <= wed_pkg::to_cost(chain_out.up);
      out_ovf_q  <= a_dropped_q;
    end else if (fin_fire) begin
      out_cost_q <= wed_pkg::to_cost(fin_cell);
      out_ovf_q  <= a_dropped_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(wed_pkg::OUT_DATA_W - wed_pkg::COST_W){1'b0}}, out_cost_q};
  assign m_axis_tuser_o  = out_ovf_q;

endmodule

/* bench/testbench.sv */
// self-checking bench for weighted_edit_distance_engine: directed and random token streams
// scored by a local minimum-cost column model; depends on wed_pkg and the engine rtl
`timescale 1ns / 100ps

module testbench;

  // mode code the block must ignore
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  // cycles the row may keep working after the last accepted item
  localparam int ROW_SETTLE = wed_pkg::MAX_LEN + 16;
  // a load waits for the row to empty, a last B symbol for the previous result
  // to leave, and the receiver may hold off (HOLD_OFF); the limit covers all of
  // these several times over
  localparam int HOLD_OFF   = 800;
  localparam int IDLE_LIMIT = 5000;

  typedef struct {
    logic [wed_pkg::COST_W-1:0] cost;
    logic                       overflow;
  } cost_item_t;

  // clock and reset
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stream in
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [wed_pkg::SYM_FIELD_W-1:0] s_tdata  = '0;   // [15:0] symbol
  logic [wed_pkg::IN_USER_W-1:0]   s_tuser  = '0;   // [1:0] mode, [2] start_req
  logic                            s_tlast  = 1'b0; // last
  // stream out
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [wed_pkg::OUT_DATA_W-1:0]  m_tdata;         // [16:0] cost, rest zero
  logic                            m_tuser;         // [0] overflow
  // register writes
  logic                            cfg_we   = 1'b0;
  logic [wed_pkg::CFG_IDX_W-1:0]   cfg_idx  = '0;
  logic [wed_pkg::PEN_W-1:0]       cfg_data = '0;

  weighted_edit_distance_engine u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // scoring model: A store, one cost column, counters and penalties
  // ---------------------------------------------------------------------------
  logic [wed_pkg::SYM_FIELD_W-1:0] seq_a [wed_pkg::MAX_LEN];
  wed_pkg::cell_t                  col   [wed_pkg::MAX_LEN + 1];
  int                              len_a      = 0;
  int                              len_b      = 0;
  logic                            a_lost     = 1'b0;
  logic [wed_pkg::PEN_W-1:0]       pen_mis    = 8'd1;
  logic [wed_pkg::PEN_W-1:0]       pen_skip_a = 8'd1;
  logic [wed_pkg::PEN_W-1:0]       pen_skip_b = 8'd1;

  cost_item_t cost_q [$];   // costs still owed by the block

  int mismatches = 0;
  int items_sent = 0;       // items the block acts on (unused mode left out)

  // idling knobs, percent: sender idles per item, receiver stalls per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_len       = 0;   // request for a long receiver hold-off

  function automatic wed_pkg::cell_t cell_plus(input wed_pkg::cell_t c,
                                               input logic [wed_pkg::PEN_W-1:0] p);
    logic [wed_pkg::CELL_W:0] s;
    s = {1'b0, c} + {{(wed_pkg::CELL_W + 1 - wed_pkg::PEN_W){1'b0}}, p};
    return (s > {1'b0, wed_pkg::CELL_MAX}) ? wed_pkg::CELL_MAX : s[wed_pkg::CELL_W-1:0];
  endfunction

  function automatic void owe_cost(input wed_pkg::cell_t c);
    cost_item_t r;
    r.cost     = (c > {1'b0, wed_pkg::COST_MAX}) ? wed_pkg::COST_MAX
                                                  : c[wed_pkg::COST_W-1:0];
    r.overflow = a_lost;
    cost_q.insert(cost_q.size(), r);
  endfunction

  // advance the model by one accepted item, queue its cost if it makes one
  function automatic void predict_alignment(input logic [1:0] mode,
                                            input logic [wed_pkg::SYM_FIELD_W-1:0] sym,
                                            input logic start, input logic last);
    wed_pkg::cell_t diag, here, best, alt, acc;
    case (mode)
      wed_pkg::MODE_LOAD_A: begin
        if (start) begin
          len_a  = 0;
          a_lost = 1'b0;
        end
        if (len_a < wed_pkg::MAX_LEN) begin
          seq_a[len_a] = sym;
          len_a++;
        end else begin
          a_lost = 1'b1;
        end
        len_b = 0;   // any B progress is abandoned
      end
      wed_pkg::MODE_FINISH: begin
        acc = '0;
        for (int i = 0; i < len_a; i++) acc = cell_plus(acc, pen_skip_a);
        len_b = 0;
        owe_cost(acc);
      end
      wed_pkg::MODE_B_SYM: begin
        // first column of a run: gap ramp down the A side
        if (start || len_b == 0) begin
          col[0] = '0;
          for (int i = 1; i <= len_a; i++) col[i] = cell_plus(col[i-1], pen_skip_a);
        end
        diag   = col[0];
        col[0] = cell_plus(diag, pen_skip_b);
        for (int i = 1; i <= len_a; i++) begin
          here = col[i];
          best = cell_plus(diag, (seq_a[i-1] == sym) ? 8'd0 : pen_mis);
          alt  = cell_plus(col[i-1], pen_skip_a);
          if (alt < best) best = alt;
          alt  = cell_plus(here, pen_skip_b);
          if (alt < best) best = alt;
          diag   = here;
          col[i] = best;
        end
        if (len_b < 511) len_b++;
        if (last) begin
          len_b = 0;
          owe_cost(col[len_a]);
        end
      end
      default: ;   // unused mode: nothing happens
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // offer one item from a falling edge, hold it until the block takes it
  task automatic send_item(input logic [1:0] mode,
                           input logic [wed_pkg::SYM_FIELD_W-1:0] sym,
                           input logic start, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      s_tvalid = 1'b0;
      repeat ($urandom_range(3)) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_tvalid = 1'b1;
    s_tdata  = sym;
    s_tuser  = {start, mode};
    s_tlast  = last;
    do @(posedge clk_i); while (!s_tready);
    predict_alignment(mode, sym, start, last);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // stop offering, collect every owed cost, then let the row run dry
  task automatic settle();
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (ROW_SETTLE) @(posedge clk_i);
  endtask

  task automatic write_penalty(input logic [wed_pkg::CFG_IDX_W-1:0] idx,
                               input logic [wed_pkg::PEN_W-1:0] v);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = v;
    case (idx)
      wed_pkg::REG_MISMATCH: pen_mis    = v;
      wed_pkg::REG_SKIP_A:   pen_skip_a = v;
      wed_pkg::REG_SKIP_B:   pen_skip_b = v;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic set_penalties(input logic [wed_pkg::PEN_W-1:0] mis,
                               input logic [wed_pkg::PEN_W-1:0] ga,
                               input logic [wed_pkg::PEN_W-1:0] gb);
    write_penalty(wed_pkg::REG_MISMATCH, mis);
    write_penalty(wed_pkg::REG_SKIP_A, ga);
    write_penalty(wed_pkg::REG_SKIP_B, gb);
  endtask

  // mostly a tiny alphabet so matches are common, sometimes any 16-bit token
  function automatic logic [wed_pkg::SYM_FIELD_W-1:0] pick_symbol();
    return ($urandom_range(3) == 0) ? wed_pkg::SYM_FIELD_W'($urandom)
                                    : wed_pkg::SYM_FIELD_W'($urandom_range(3));
  endfunction

  // short A, short B run, last on the final B symbol
  task automatic send_short_pair(input int n_a, input int n_b);
    for (int i = 0; i < n_a; i++)
      send_item(wed_pkg::MODE_LOAD_A, pick_symbol(), i == 0, 1'b0);
    for (int j = 0; j < n_b; j++)
      send_item(wed_pkg::MODE_B_SYM, pick_symbol(), j == 0, j == n_b - 1);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset penalties of one, the four modes, edge symbols
  task automatic test_reset_values();
    send_item(wed_pkg::MODE_FINISH, 16'hFFFF, 1'b1, 1'b1);  // empty A, control bits ignored
    send_item(wed_pkg::MODE_B_SYM, 16'h0000, 1'b1, 1'b1);   // B against empty A
    send_item(wed_pkg::MODE_LOAD_A, 16'h0005, 1'b1, 1'b1);  // tlast ignored on a load
    send_item(wed_pkg::MODE_LOAD_A, 16'hFFFF, 1'b0, 1'b0);
    send_item(wed_pkg::MODE_B_SYM, 16'h0005, 1'b1, 1'b0);
    send_item(wed_pkg::MODE_B_SYM, 16'hFFFF, 1'b0, 1'b1);
    send_item(MODE_UNUSED, 16'hA5A5, 1'b1, 1'b1);           // ignored entirely
    send_item(wed_pkg::MODE_B_SYM, 16'h0000, 1'b0, 1'b0);   // starts afresh after a result
    send_item(wed_pkg::MODE_B_SYM, 16'hFFFF, 1'b0, 1'b1);
    send_item(wed_pkg::MODE_FINISH, 16'h0000, 1'b0, 1'b0);
    settle();
  endtask

  // restart, load during B progress, register extremes
  task automatic test_restart_cases();
    set_penalties(8'd3, 8'd0, 8'd255);
    send_item(wed_pkg::MODE_LOAD_A, 16'h0001, 1'b1, 1'b0);
    send_item(wed_pkg::MODE_LOAD_A, 16'h0002, 1'b0, 1'b0);
    send_item(wed_pkg::MODE_B_SYM, 16'h0002, 1'b1, 1'b0);
    send_item(wed_pkg::MODE_B_SYM, 16'h0001, 1'b0, 1'b0);
    send_item(wed_pkg::MODE_LOAD_A, 16'h0003, 1'b0, 1'b0);  // appends, abandons the B run
    send_item(wed_pkg::MODE_B_SYM, 16'h0003, 1'b0, 1'b1);
    send_item(wed_pkg::MODE_B_SYM, 16'h0001, 1'b1, 1'b0);
    send_item(wed_pkg::MODE_B_SYM, 16'h0002, 1'b0, 1'b0);
    send_item(wed_pkg::MODE_B_SYM, 16'h0003, 1'b1, 1'b1);   // restart within a run
    settle();
    set_penalties(8'd255, 8'd255, 8'd0);
    send_short_pair(3, 4);
    send_item(wed_pkg::MODE_FINISH, 16'h1234, 1'b1, 1'b1);
    settle();
    set_penalties(8'd0, 8'd0, 8'd0);
    send_short_pair(2, 2);
    settle();
  endtask

  // more A symbols than the store holds: dropped and flagged until a new start
  task automatic test_capacity_overflow();
    set_penalties(8'd1, 8'd2, 8'd3);
    for (int i = 0; i < wed_pkg::MAX_LEN + 6; i++)
      send_item(wed_pkg::MODE_LOAD_A, pick_symbol(), i == 0, 1'b0);
    for (int j = 0; j < 3; j++)
      send_item(wed_pkg::MODE_B_SYM, pick_symbol(), j == 0, j == 2);
    send_item(wed_pkg::MODE_FINISH, 16'h0000, 1'b0, 1'b0);
    send_item(wed_pkg::MODE_LOAD_A, 16'h0007, 1'b1, 1'b0);  // start clears the flag
    send_item(wed_pkg::MODE_FINISH, 16'h0000, 1'b0, 1'b0);
    settle();
  endtask

  // long B run at the largest penalties: costs grow large without a match
  task automatic test_saturation();
    set_penalties(8'd255, 8'd255, 8'd255);
    send_item(wed_pkg::MODE_LOAD_A, 16'h0011, 1'b1, 1'b0);
    send_item(wed_pkg::MODE_LOAD_A, 16'h0022, 1'b0, 1'b0);
    for (int j = 0; j < 120; j++)
      send_item(wed_pkg::MODE_B_SYM, 16'h0033, j == 0, j == 119);
    settle();
  endtask

  // well-formed A then B runs with random content, plus some noise
  task automatic send_random_sequence();
    logic [1:0] mode;
    int n_a, n_b, r;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 4)) begin
        mode = 2'($urandom_range(3));
        send_item(mode, wed_pkg::SYM_FIELD_W'($urandom), 1'($urandom), 1'($urandom));
      end
      return;
    end
    r   = $urandom_range(99);
    n_a = (r < 86) ? $urandom_range(1, 8) : (r < 99) ? $urandom_range(9, 48)
                                                     : $urandom_range(200, 270);
    for (int i = 0; i < n_a; i++)
      send_item(wed_pkg::MODE_LOAD_A, pick_symbol(), (i == 0) && ($urandom_range(9) != 0),
                1'($urandom));
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(99) < 15) begin
        send_item(wed_pkg::MODE_FINISH, pick_symbol(), 1'($urandom), 1'($urandom));
      end else begin
        n_b = ($urandom_range(9) != 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        for (int j = 0; j < n_b; j++)
          send_item(wed_pkg::MODE_B_SYM, pick_symbol(),
                    (j == 0) ? 1'($urandom) : ($urandom_range(19) == 0), j == n_b - 1);
      end
    end
  endtask

  // four idling phases, each with its own penalty setting
  task automatic test_random_streams();
    int phase_start;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_penalties(8'd255, 8'd255, 8'd255);
          send_idle_pct = 0;  recv_stall_pct = 0;
        end
        1: begin
          set_penalties(8'd0, 8'($urandom), 8'($urandom));
          send_idle_pct = 54; recv_stall_pct = 0;
        end
        2: begin
          set_penalties(8'($urandom), 8'($urandom), 8'($urandom));
          send_idle_pct = 0;  recv_stall_pct = 54;
        end
        default: begin
          set_penalties(8'($urandom), 8'd0, 8'($urandom_range(1, 255)));
          send_idle_pct = 19; recv_stall_pct = 19;
        end
      endcase
      phase_start = items_sent;
      while (items_sent - phase_start < 60) send_random_sequence();
      settle();
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off long enough to stall the input, then the sender
  // pauses until every owed cost has come back
  task automatic test_backpressure();
    set_penalties(8'd2, 8'd1, 8'd1);
    hold_len = HOLD_OFF;
    repeat (6) send_short_pair(3, 2);
    @(negedge clk_i);
    s_tvalid = 1'b0;
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (4) send_short_pair(2, 3);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // receiver: random stalls, or a counted hold-off on request
  // ---------------------------------------------------------------------------
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      m_tready = 1'b0;
      hold_left--;
    end else begin
      m_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // result check against the oldest owed cost
  always @(posedge clk_i) begin
    cost_item_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      if (cost_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item, expected none, got cost %0d overflow %0b",
                 $time, m_tdata, m_tuser);
      end else begin
        want = cost_q.pop_front();
        if (m_tdata !== wed_pkg::OUT_DATA_W'(want.cost)) begin
          mismatches++;
          $display("%0t: cost mismatch, expected %0d, got %0d",
                   $time, want.cost, m_tdata);
        end
        if (m_tuser !== want.overflow) begin
          mismatches++;
          $display("%0t: overflow mismatch, expected %0b, got %0b",
                   $time, want.overflow, m_tuser);
        end
      end
    end
  end

  // watchdog: too long with no item moving on either side
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else if (rst_ni) begin
      quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // sequence of tests
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_values();
    test_restart_cases();
    test_capacity_overflow();
    test_saturation();
    test_backpressure();
    test_random_streams();
    while (cost_q.size() != 0) @(posedge clk_i);
    repeat (ROW_SETTLE) @(posedge clk_i);
    if (mismatches == 0 && cost_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/wed_pkg.sv
hdl/wed_cell.sv
hdl/weighted_edit_distance_engine.sv
bench/testbench.sv
